// ===== hw/rtl/stip_pkg.sv =====
// ----------------------------------------------------------------------------
// stip_pkg: shared types for the sorted table
// Request and response payloads, table entry, operation and status codes,
// sequencer states and register addresses.
// ----------------------------------------------------------------------------
package stip_pkg;

   localparam int KeyWidth   = 64;
   localparam int ValueWidth = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PURGE  = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_INDEX = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_PLACE,
      ST_PURGE,
      ST_READ
   } state_type;

   typedef struct packed {
      op_type                  operation;
      logic [KeyWidth-1:0]     key;
      logic [ValueWidth-1:0]   enrolled;
      logic [4:0]              index;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [KeyWidth-1:0]     entry_key;
      logic [ValueWidth-1:0]   entry_value;
      logic [5:0]              entries_in_table;
      logic [5:0]              removed;
   } rsp_type;

   typedef struct packed {
      logic [KeyWidth-1:0]     key;
      logic [ValueWidth-1:0]   value;
   } entry_type;

   // Register select is byte address bit 2.
   localparam logic CSR_MIN_ENROLLMENT = 1'b0;
   localparam logic CSR_MAX_ENROLLMENT = 1'b1;

   localparam logic [ValueWidth-1:0] MIN_ENROLLMENT_RESET = 5'd10;
   localparam logic [ValueWidth-1:0] MAX_ENROLLMENT_RESET = 5'd25;

endpackage

// ===== hw/rtl/sorted_table_insert_and_purge.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_and_purge: sorted (key, value) table
// Insert with capacity and value bound, threshold purge, indexed read.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. Every command
// gives exactly one result, shown on rsp_data for one cycle with rsp_valid
// high; the receiver cannot stall it, so it must take the result in that
// cycle. Entries live in a single-port-write, single-port-read memory and a
// small sequencer walks it one entry per cycle. An insert walks down from
// the top entry, moving each entry whose key is not below the new key up by
// one slot. A purge reads every entry once and writes back the survivors in
// order. A rejected insert, a read of an invalid index, a purge of an empty
// table and the unused operation answer in the cycle after the transfer.
// The next command may be transferred in the same cycle that a result is
// shown. Configuration registers are to be written over the APB port only
// while the block is idle, which the block itself does not enforce;
// register 0 (min_enrollment) is at byte address 0 and register 1
// (max_enrollment) at byte address 4.
// ----------------------------------------------------------------------------
module sorted_table_insert_and_purge import stip_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [ValueWidth-1:0] min_ff, max_ff;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         wr_ff, wr_in;
   logic [KeyWidth-1:0]   key_ff, key_in;
   logic [ValueWidth-1:0] val_ff, val_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   entry_type             mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   entry_type             mem_rd_data;

   logic                  full;
   logic                  out_of_range;
   logic                  index_ok;
   logic                  key_not_below;
   logic                  keep;
   logic                  last;
   logic [CW-1:0]         wr_next;

   // Shared decisions of the sequencer.
   assign full          = (count_ff == CW'(CAPACITY));
   assign out_of_range  = (req_data.enrolled > max_ff);
   assign index_ok      = (32'(req_data.index) < 32'(count_ff));
   assign key_not_below = (mem_rd_data.key >= key_ff);
   assign keep          = (mem_rd_data.value >= min_ff);
   assign last          = (CW'(ptr_ff) == CW'(count_ff - CW'(1)));
   assign wr_next       = wr_ff + CW'(keep);

   stip_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.operation)
                  OP_INSERT: begin
                     if (full || out_of_range) begin
                        state_in = ST_IDLE;
                     end else if (count_ff == '0) begin
                        state_in = ST_PLACE;
                     end else begin
                        state_in = ST_INSERT;
                     end
                  end
                  OP_PURGE: state_in = (count_ff == '0) ? ST_IDLE : ST_PURGE;
                  OP_READ:  state_in = index_ok ? ST_READ : ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_INSERT: begin
            if (key_not_below) begin
               state_in = (ptr_ff == '0) ? ST_PLACE : ST_INSERT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PLACE: state_in = ST_IDLE;
         ST_PURGE: state_in = last ? ST_IDLE : ST_PURGE;
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and the result.
   always_comb begin
      ptr_in       = ptr_ff;
      wr_in        = wr_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = STATUS_OK;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = AW'(ptr_ff + AW'(1));
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = AW'(ptr_ff - AW'(1));
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_data.key;
               val_in = req_data.enrolled;
               case (req_data.operation)
                  OP_INSERT: begin
                     // The walk starts at the top entry.
                     mem_rd_addr = AW'(count_ff - CW'(1));
                     ptr_in      = AW'(count_ff - CW'(1));
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else if (out_of_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_RANGE;
                     end
                  end
                  OP_PURGE: begin
                     mem_rd_addr = '0;
                     ptr_in      = '0;
                     wr_in       = '0;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     mem_rd_addr = AW'(req_data.index);
                     if (!index_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_INDEX;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            mem_wr_en = 1'b1;
            if (key_not_below) begin
               // Move this entry up one slot and look at the next lower one.
               ptr_in = AW'(ptr_ff - AW'(1));
            end else begin
               // The new pair goes just above the first smaller key.
               mem_wr_data.key   = key_ff;
               mem_wr_data.value = val_ff;
               count_in          = count_ff + CW'(1);
               rsp_valid_in      = 1'b1;
            end
         end
         ST_PLACE: begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = '0;
            mem_wr_data.key   = key_ff;
            mem_wr_data.value = val_ff;
            count_in          = count_ff + CW'(1);
            rsp_valid_in      = 1'b1;
         end
         ST_PURGE: begin
            // Survivors are written back in order at the write pointer.
            mem_wr_en   = keep;
            mem_wr_addr = wr_ff[AW-1:0];
            wr_in       = wr_next;
            mem_rd_addr = AW'(ptr_ff + AW'(1));
            ptr_in      = AW'(ptr_ff + AW'(1));
            if (last) begin
               count_in       = wr_next;
               rsp_valid_in   = 1'b1;
               rsp_in.removed = 6'(count_ff - wr_next);
            end
         end
         ST_READ: begin
            rsp_valid_in       = 1'b1;
            rsp_in.entry_key   = mem_rd_data.key;
            rsp_in.entry_value = mem_rd_data.value;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      rsp_in.entries_in_table = 6'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      wr_ff  <= wr_in;
      key_ff <= key_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   // Configuration registers. A write transfer completes in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_ENROLLMENT_RESET;
         max_ff <= MAX_ENROLLMENT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == CSR_MIN_ENROLLMENT) begin
            min_ff <= csr_pwdata[ValueWidth-1:0];
         end else begin
            max_ff <= csr_pwdata[ValueWidth-1:0];
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_MIN_ENROLLMENT) ?
                       32'(min_ff) : 32'(max_ff);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/stip_store.sv =====
// ----------------------------------------------------------------------------
// stip_store: entry memory of the sorted table
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stip_store import stip_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
